@@ src/otr_pkg.sv @@
// Package for the one-wire temperature reader: phase codes, bus timing
// constants, command bytes and the structs shared by the core and top level.
// No dependencies.
package otr_pkg;

   localparam int TicksWidth = 8;
   localparam int WaitWidth  = 20;
   localparam int TempWidth  = 12;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_RST_HIGH  = 4'd1,
      PH_RST_LOW   = 4'd2,
      PH_RST_REL   = 4'd3,
      PH_PRESENCE  = 4'd4,
      PH_RST_TAIL  = 4'd5,
      PH_WR_LOW    = 4'd6,
      PH_WR_DATA   = 4'd7,
      PH_CONV_WAIT = 4'd8,
      PH_RD_LOW    = 4'd9,
      PH_RD_SAMPLE = 4'd10,
      PH_RD_REC    = 4'd11
   } phase_type;

   typedef enum logic [0:0] {
      REG_TICKS_PER_US    = 1'b0,
      REG_CONVERT_WAIT_US = 1'b1
   } reg_index_type;

   localparam logic [7:0] CMD_SKIP     = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_PAD = 8'hBE;

   // Bus timing in microseconds
   localparam logic [WaitWidth-1:0] T_RST_HIGH = 20'd10;
   localparam logic [WaitWidth-1:0] T_RST_LOW  = 20'd600;
   localparam logic [WaitWidth-1:0] T_RST_REL  = 20'd100;
   localparam logic [WaitWidth-1:0] T_RST_TAIL = 20'd400;
   localparam logic [WaitWidth-1:0] T_WR_LOW   = 20'd2;
   localparam logic [WaitWidth-1:0] T_SLOT     = 20'd60;
   localparam logic [WaitWidth-1:0] T_RD_LOW   = 20'd5;

   // Byte sequence steps
   localparam logic [2:0] STEP_CONVERT  = 3'd1;
   localparam logic [2:0] STEP_CONVWAIT = 3'd2;
   localparam logic [2:0] STEP_READ_PAD = 3'd3;
   localparam logic [2:0] STEP_LOW_BYTE = 3'd4;
   localparam logic [2:0] STEP_HI_BYTE  = 3'd5;

   typedef struct packed {
      logic [TicksWidth-1:0] ticks_per_us;
      logic [WaitWidth-1:0]  convert_wait_us;
   } cfg_type;

   typedef struct packed {
      logic                        drive_low;
      logic                        busy_res;
      logic                        done_res;
      logic signed [TempWidth-1:0] temperature;
   } result_type;

endpackage

@@ src/otr_if.sv @@
// Handshake channel interfaces for the one-wire temperature reader:
// request, response and register write channels. Depends on otr_pkg.
interface otr_req_if;
   logic valid;
   logic ready;
   logic kind;
   logic line_level;
   modport source (output valid, output kind, output line_level, input ready);
   modport sink (input valid, input kind, input line_level, output ready);
endinterface

interface otr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                drive_low;
   logic                                busy_res;
   logic                                done_res;
   logic signed [otr_pkg::TempWidth-1:0] temperature;
   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output temperature, input ready);
   modport sink (input valid, input drive_low, input busy_res, input done_res,
                 input temperature, output ready);
endinterface

interface otr_csr_if;
   logic                             valid;
   logic                             ready;
   logic                             index;
   logic [otr_pkg::WaitWidth-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/otr_core.sv @@
// Bus sequencer of the one-wire temperature reader: phase, timers, bit and
// byte counters, shift register and reading. Depends on otr_pkg.
module otr_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic                kind,
   input  logic                line_level,
   input  otr_pkg::cfg_type    cfg,
   output otr_pkg::result_type result
);
   import otr_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [2:0]           byte_step_ff, byte_step_in;
   logic [2:0]           bit_index_ff, bit_index_in;
   logic [7:0]           shift_byte_ff, shift_byte_in;
   logic [WaitWidth-1:0] us_timer_ff, us_timer_in;
   logic [7:0]           tick_prescale_ff, tick_prescale_in;
   logic [7:0]           low_byte_ff, low_byte_in;
   logic [TempWidth-1:0] reading_ff, reading_in;
   logic                 done;
   logic [7:0]           tpu;
   logic [7:0]           pre;
   logic [WaitWidth-1:0] tmr;
   logic [2:0]           step;
   logic                 drive;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         byte_step_ff     <= '0;
         bit_index_ff     <= '0;
         shift_byte_ff    <= '0;
         us_timer_ff      <= '0;
         tick_prescale_ff <= '0;
         low_byte_ff      <= '0;
         reading_ff       <= '0;
      end else if (fire) begin
         phase_ff         <= phase_in;
         byte_step_ff     <= byte_step_in;
         bit_index_ff     <= bit_index_in;
         shift_byte_ff    <= shift_byte_in;
         us_timer_ff      <= us_timer_in;
         tick_prescale_ff <= tick_prescale_in;
         low_byte_ff      <= low_byte_in;
         reading_ff       <= reading_in;
      end
   end

   assign tpu = (cfg.ticks_per_us == '0) ? 8'd1 : cfg.ticks_per_us;
   assign pre = tick_prescale_ff + 8'd1;
   assign tmr = (us_timer_ff != '0) ? us_timer_ff - 20'd1 : '0;
   assign step = byte_step_ff + 3'd1;

   always_comb begin
      phase_in         = phase_ff;
      byte_step_in     = byte_step_ff;
      bit_index_in     = bit_index_ff;
      shift_byte_in    = shift_byte_ff;
      us_timer_in      = us_timer_ff;
      tick_prescale_in = tick_prescale_ff;
      low_byte_in      = low_byte_ff;
      reading_in       = reading_ff;
      done             = 1'b0;

      if (kind) begin
         if (phase_ff == PH_IDLE) begin
            byte_step_in     = '0;
            bit_index_in     = '0;
            shift_byte_in    = '0;
            phase_in         = PH_RST_HIGH;
            us_timer_in      = T_RST_HIGH;
            tick_prescale_in = '0;
         end
      end else if (phase_ff == PH_IDLE) begin
         // tick while idle: hold everything
      end else if (phase_ff == PH_PRESENCE) begin
         if (!line_level) begin
            phase_in         = PH_RST_TAIL;
            us_timer_in      = T_RST_TAIL;
            tick_prescale_in = '0;
         end
      end else if (phase_ff == PH_RD_SAMPLE) begin
         shift_byte_in    = {line_level, shift_byte_ff[7:1]};
         phase_in         = PH_RD_REC;
         us_timer_in      = T_SLOT;
         tick_prescale_in = '0;
      end else if (pre < tpu) begin
         tick_prescale_in = pre;
      end else if (tmr != '0) begin
         tick_prescale_in = '0;
         us_timer_in      = tmr;
      end else begin
         // timer expired: advance the sequence
         tick_prescale_in = '0;
         us_timer_in      = '0;
         case (phase_ff)
            PH_RST_HIGH: begin
               phase_in    = PH_RST_LOW;
               us_timer_in = T_RST_LOW;
            end
            PH_RST_LOW: begin
               phase_in    = PH_RST_REL;
               us_timer_in = T_RST_REL;
            end
            PH_RST_REL: begin
               phase_in = PH_PRESENCE;
            end
            PH_RST_TAIL: begin
               shift_byte_in = CMD_SKIP;
               bit_index_in  = '0;
               phase_in      = PH_WR_LOW;
               us_timer_in   = T_WR_LOW;
            end
            PH_WR_LOW: begin
               phase_in    = PH_WR_DATA;
               us_timer_in = T_SLOT;
            end
            PH_WR_DATA: begin
               shift_byte_in = {1'b0, shift_byte_ff[7:1]};
               if (bit_index_ff == 3'd7) begin
                  byte_step_in = step;
                  case (step)
                     STEP_CONVERT: begin
                        shift_byte_in = CMD_CONVERT;
                        bit_index_in  = '0;
                        phase_in      = PH_WR_LOW;
                        us_timer_in   = T_WR_LOW;
                     end
                     STEP_CONVWAIT: begin
                        if (cfg.convert_wait_us != '0) begin
                           phase_in    = PH_CONV_WAIT;
                           us_timer_in = cfg.convert_wait_us;
                        end else begin
                           phase_in    = PH_RST_HIGH;
                           us_timer_in = T_RST_HIGH;
                        end
                     end
                     STEP_READ_PAD: begin
                        shift_byte_in = CMD_READ_PAD;
                        bit_index_in  = '0;
                        phase_in      = PH_WR_LOW;
                        us_timer_in   = T_WR_LOW;
                     end
                     STEP_LOW_BYTE: begin
                        shift_byte_in = '0;
                        bit_index_in  = '0;
                        phase_in      = PH_RD_LOW;
                        us_timer_in   = T_RD_LOW;
                     end
                     default: begin
                        byte_step_in = '0;
                        phase_in     = PH_IDLE;
                     end
                  endcase
               end else begin
                  bit_index_in = bit_index_ff + 3'd1;
                  phase_in     = PH_WR_LOW;
                  us_timer_in  = T_WR_LOW;
               end
            end
            PH_CONV_WAIT: begin
               phase_in    = PH_RST_HIGH;
               us_timer_in = T_RST_HIGH;
            end
            PH_RD_LOW: begin
               phase_in = PH_RD_SAMPLE;
            end
            PH_RD_REC: begin
               if (bit_index_ff != 3'd7) begin
                  bit_index_in = bit_index_ff + 3'd1;
                  phase_in     = PH_RD_LOW;
                  us_timer_in  = T_RD_LOW;
               end else if (byte_step_ff == STEP_LOW_BYTE) begin
                  low_byte_in   = shift_byte_ff;
                  byte_step_in  = STEP_HI_BYTE;
                  shift_byte_in = '0;
                  bit_index_in  = '0;
                  phase_in      = PH_RD_LOW;
                  us_timer_in   = T_RD_LOW;
               end else begin
                  if (byte_step_ff == STEP_HI_BYTE) begin
                     reading_in = {shift_byte_ff[3:0], low_byte_ff};
                     done       = 1'b1;
                  end
                  byte_step_in = '0;
                  phase_in     = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      case (phase_in)
         PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: drive = 1'b1;
         PH_WR_DATA:                       drive = ~shift_byte_in[0];
         default:                          drive = 1'b0;
      endcase
   end

   assign result.drive_low   = drive;
   assign result.busy_res    = (phase_in != PH_IDLE);
   assign result.done_res    = done;
   assign result.temperature = signed'(reading_in);

endmodule

@@ src/one_wire_temperature_reader.sv @@
// One-wire temperature reader, top level: input register, sequencer core,
// result register and configuration registers. Depends on otr_pkg, otr_if, otr_core.
// Each accepted transaction is held in the input register; the core's result is then registered in the result register.
// Throughput: one transaction per cycle while the result register is free to take it;
// stalls come only from rsp.ready.
// Reset: phase idle, counters and reading cleared, ticks_per_us = 1,
// convert_wait_us = 0; no clearing pass.
module one_wire_temperature_reader (
   input logic     clock,
   input logic     reset,
   otr_req_if.sink   req,
   otr_rsp_if.source rsp,
   otr_csr_if.sink   csr
);
   import otr_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic       in_kind_ff;
   logic       in_line_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type result;
   cfg_type    cfg_ff;
   logic       out_free;
   logic       fire;

   assign out_free  = ~out_valid_ff | rsp.ready;
   assign fire      = in_valid_ff & out_free;
   assign req.ready = ~in_valid_ff | out_free;
   assign csr.ready = 1'b1;

   assign in_valid_in  = req.valid | (in_valid_ff & ~out_free);
   assign out_valid_in = fire | (out_valid_ff & ~rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         cfg_ff.ticks_per_us    <= 8'd1;
         cfg_ff.convert_wait_us <= '0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
         if (csr.valid) begin
            case (reg_index_type'(csr.index))
               REG_TICKS_PER_US:    cfg_ff.ticks_per_us    <= csr.data[TicksWidth-1:0];
               REG_CONVERT_WAIT_US: cfg_ff.convert_wait_us <= csr.data;
               default: ;
            endcase
         end
      end
   end

   // payload registers: load on acceptance, hold while stalled
   always_ff @(posedge clock) begin
      if (req.valid & req.ready) begin
         in_kind_ff <= req.kind;
         in_line_ff <= req.line_level;
      end
      if (fire) begin
         out_ff <= result;
      end
   end

   otr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .kind       (in_kind_ff),
      .line_level (in_line_ff),
      .cfg        (cfg_ff),
      .result     (result)
   );

   assign rsp.valid       = out_valid_ff;
   assign rsp.drive_low   = out_ff.drive_low;
   assign rsp.busy_res    = out_ff.busy_res;
   assign rsp.done_res    = out_ff.done_res;
   assign rsp.temperature = out_ff.temperature;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for one_wire_temperature_reader: runs full temperature reads
// against a cycle-free sequencer model, with random gaps on requests and random response stalls.
// Depends on otr_pkg, otr_if and the one_wire_temperature_reader RTL.
module testbench;
   import otr_pkg::*;

   localparam int CycleLimit   = 5_000_000;
   localparam int PressureAt   = 1500;
   localparam int PressureHold = 300;

   typedef struct {
      logic       kind;
      logic       line_level;
      bit         typed;
      result_type want;
   } stim_row_type;

   typedef struct {
      logic [7:0]  tpu;
      logic [19:0] wait_us;
      bit          with_read;
      logic [15:0] word;    // sensor bytes, LSB first; zero means random
      int          odds;    // presence pulse comes with chance 1 in odds+1 per tick
   } setting_row_type;

   setting_row_type settings [5] = '{
      '{8'd255, 20'hFFFFF, 1'b0, 16'h0000, 0},
      '{8'd0,   20'd0,     1'b1, 16'hF800, 15},
      '{8'd2,   20'd17,    1'b1, 16'hFFFF, 15},
      '{8'd1,   20'd1,     1'b1, 16'h0000, 300},
      '{8'd1,   20'd250,   1'b1, 16'h0000, 7}
   };

   logic clock;
   logic reset;

   otr_req_if req_ch ();
   otr_rsp_if rsp_ch ();
   otr_csr_if csr_ch ();

   one_wire_temperature_reader uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // Sequencer model state and its copy of the registers
   phase_type   seq_phase;
   logic [2:0]  seq_step;
   logic [2:0]  bit_count;
   logic [7:0]  shift_reg;
   logic [19:0] us_left;
   logic [7:0]  prescale;
   logic [7:0]  lsb_hold;
   logic [11:0] last_reading;
   logic        finished_now;
   logic [7:0]  cfg_ticks;
   logic [19:0] cfg_wait;

   result_type expected_results [$];

   int cycle_count  = 0;
   int items_sent   = 0;
   int results_seen = 0;
   int reads_done   = 0;
   int error_count  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Timeout after %0d cycles, %0d results still due", cycle_count,
                  expected_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic void go_phase(input phase_type p, input logic [19:0] us);
      seq_phase = p;
      us_left   = us;
      prescale  = '0;
   endfunction

   function automatic void send_byte(input logic [7:0] b);
      shift_reg = b;
      bit_count = '0;
      go_phase(PH_WR_LOW, T_WR_LOW);
   endfunction

   function automatic void fetch_byte();
      shift_reg = '0;
      bit_count = '0;
      go_phase(PH_RD_LOW, T_RD_LOW);
   endfunction

   // Apply one transaction to the model and return the result it must produce
   function automatic result_type sequencer_step(input logic k, input logic ln);
      logic [7:0] tpu;
      logic       drive;
      finished_now = 1'b0;
      if (k) begin
         if (seq_phase == PH_IDLE) begin
            seq_step  = '0;
            bit_count = '0;
            shift_reg = '0;
            go_phase(PH_RST_HIGH, T_RST_HIGH);
         end
      end else if (seq_phase == PH_PRESENCE) begin
         if (!ln) go_phase(PH_RST_TAIL, T_RST_TAIL);
      end else if (seq_phase == PH_RD_SAMPLE) begin
         shift_reg = {ln, shift_reg[7:1]};
         go_phase(PH_RD_REC, T_SLOT);
      end else if (seq_phase != PH_IDLE) begin
         tpu = (cfg_ticks == '0) ? 8'd1 : cfg_ticks;
         prescale = prescale + 8'd1;
         if (prescale >= tpu) begin
            prescale = '0;
            if (us_left != '0) us_left = us_left - 20'd1;
            if (us_left == '0) begin
               case (seq_phase)
                  PH_RST_HIGH:  go_phase(PH_RST_LOW, T_RST_LOW);
                  PH_RST_LOW:   go_phase(PH_RST_REL, T_RST_REL);
                  PH_RST_REL:   go_phase(PH_PRESENCE, '0);
                  PH_RST_TAIL:  send_byte(CMD_SKIP);
                  PH_WR_LOW:    go_phase(PH_WR_DATA, T_SLOT);
                  PH_CONV_WAIT: go_phase(PH_RST_HIGH, T_RST_HIGH);
                  PH_RD_LOW:    go_phase(PH_RD_SAMPLE, '0);
                  PH_WR_DATA: begin
                     shift_reg = shift_reg >> 1;
                     if (bit_count == 3'd7) begin
                        // byte sent: advance through the command list
                        seq_step = seq_step + 3'd1;
                        case (seq_step)
                           STEP_CONVERT: send_byte(CMD_CONVERT);
                           STEP_CONVWAIT: begin
                              if (cfg_wait != '0) go_phase(PH_CONV_WAIT, cfg_wait);
                              else go_phase(PH_RST_HIGH, T_RST_HIGH);
                           end
                           STEP_READ_PAD: send_byte(CMD_READ_PAD);
                           STEP_LOW_BYTE: fetch_byte();
                           default: begin
                              seq_step = '0;
                              go_phase(PH_IDLE, '0);
                           end
                        endcase
                     end else begin
                        bit_count = bit_count + 3'd1;
                        go_phase(PH_WR_LOW, T_WR_LOW);
                     end
                  end
                  PH_RD_REC: begin
                     if (bit_count != 3'd7) begin
                        bit_count = bit_count + 3'd1;
                        go_phase(PH_RD_LOW, T_RD_LOW);
                     end else if (seq_step == STEP_LOW_BYTE) begin
                        lsb_hold = shift_reg;
                        seq_step = STEP_HI_BYTE;
                        fetch_byte();
                     end else begin
                        if (seq_step == STEP_HI_BYTE) begin
                           last_reading = {shift_reg[3:0], lsb_hold};
                           finished_now = 1'b1;
                        end
                        seq_step = '0;
                        go_phase(PH_IDLE, '0);
                     end
                  end
                  default: go_phase(PH_IDLE, '0);
               endcase
            end
         end
      end
      case (seq_phase)
         PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: drive = 1'b1;
         PH_WR_DATA: drive = ~shift_reg[0];
         default: drive = 1'b0;
      endcase
      return '{drive, seq_phase != PH_IDLE, finished_now, last_reading};
   endfunction

   function automatic stim_row_type make_row(input logic k, input logic ln, input bit typed,
                                             input logic drv, input logic bsy);
      stim_row_type r;
      r.kind       = k;
      r.line_level = ln;
      r.typed      = typed;
      r.want       = '{drv, bsy, 1'b0, 12'sd0};
      return r;
   endfunction

   // Mostly back to back, some short gaps, a few long ones
   function automatic int gap_cycles(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(5, 12);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= 30)
         $display("MISMATCH at result %0d, %s: got %0d, expected %0d", results_seen, what,
                  got, want);
   endtask

   task automatic offer(input logic k, input logic ln, input bit typed, input result_type want);
      result_type modeled;
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= k;
      req_ch.line_level <= ln;
      do @(posedge clock); while (!req_ch.ready);
      modeled = sequencer_step(k, ln);
      expected_results.push_back(typed ? want : modeled);
      items_sent++;
   endtask

   task automatic pause_sender();
      int n;
      n = gap_cycles((items_sent / 600) % 5 == 3);
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_quiet(input int tail);
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // Leaves valid high; the caller drops it after the last write
   task automatic write_register(input reg_index_type idx, input logic [19:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == REG_TICKS_PER_US) cfg_ticks = value[7:0];
      else cfg_wait = value;
   endtask

   // Drive a read to completion, acting as the sensor on the bus
   task automatic run_read(input logic [15:0] word, input int odds);
      logic ln;
      int   pos;
      if (seq_phase == PH_IDLE) begin
         offer(1'b1, 1'($urandom_range(0, 1)), 1'b0, '0);
         pause_sender();
      end
      while (seq_phase != PH_IDLE) begin
         if ($urandom_range(0, 29) == 0) begin
            // start while busy must be dropped
            offer(1'b1, 1'($urandom_range(0, 1)), 1'b0, '0);
         end else begin
            case (seq_phase)
               PH_PRESENCE: ln = ($urandom_range(0, odds) == 0) ? 1'b0 : 1'b1;
               PH_RD_SAMPLE: begin
                  pos = (seq_step == STEP_HI_BYTE) ? 8 + bit_count : bit_count;
                  ln  = word[pos];
               end
               default: ln = 1'($urandom_range(0, 1));
            endcase
            offer(1'b0, ln, 1'b0, '0);
         end
         pause_sender();
      end
      repeat ($urandom_range(2, 6)) begin
         offer(1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
         pause_sender();
      end
   endtask

   // Response side: random back-pressure plus one long hold-off
   initial begin
      result_type want;
      int         stall_left;
      int         hold_left;
      bit         hold_done;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
               if (expected_results.size() == 0) begin
                  report_mismatch("result with nothing outstanding", 1, 0);
               end else begin
                  want = expected_results.pop_front();
                  if (rsp_ch.drive_low !== want.drive_low)
                     report_mismatch("drive_low", rsp_ch.drive_low, want.drive_low);
                  if (rsp_ch.busy_res !== want.busy_res)
                     report_mismatch("busy_res", rsp_ch.busy_res, want.busy_res);
                  if (rsp_ch.done_res !== want.done_res)
                     report_mismatch("done_res", rsp_ch.done_res, want.done_res);
                  if (rsp_ch.temperature !== want.temperature)
                     report_mismatch("temperature", rsp_ch.temperature, want.temperature);
               end
               results_seen++;
               if (rsp_ch.done_res === 1'b1) reads_done++;
            end
            if (!hold_done && results_seen >= PressureAt) begin
               hold_left = PressureHold;
               hold_done = 1'b1;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
               stall_left--;
               rsp_ch.ready <= 1'b0;
            end else begin
               stall_left = gap_cycles((cycle_count / 800) % 5 == 2);
               rsp_ch.ready <= (stall_left == 0);
               if (stall_left > 0) stall_left--;
            end
         end
      end
   end

   // Request side: directed table, a read under reset defaults, then a read or idle ticks per register setting
   initial begin
      stim_row_type plan [$];
      logic [15:0]  word;
      seq_phase    = PH_IDLE;
      seq_step     = '0;
      bit_count    = '0;
      shift_reg    = '0;
      us_left      = '0;
      prescale     = '0;
      lsb_hold     = '0;
      last_reading = '0;
      finished_now = 1'b0;
      cfg_ticks    = 8'd1;
      cfg_wait     = '0;

      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.kind       <= 1'b0;
      req_ch.line_level <= 1'b0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= REG_TICKS_PER_US;
      csr_ch.data       <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Ticks while idle, start, start while busy, then the 10 us released lead-in
      plan.push_back(make_row(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      plan.push_back(make_row(1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
      plan.push_back(make_row(1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
      plan.push_back(make_row(1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
      for (int i = 0; i < 9; i++) plan.push_back(make_row(1'b0, 1'(i), 1'b0, 1'b0, 1'b1));
      plan.push_back(make_row(1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
      for (int i = 0; i < 5; i++) plan.push_back(make_row(1'b0, 1'(i), 1'b0, 1'b1, 1'b1));
      plan.push_back(make_row(1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
      plan.push_back(make_row(1'b0, 1'b0, 1'b0, 1'b1, 1'b1));

      foreach (plan[i]) begin
         offer(plan[i].kind, plan[i].line_level, plan[i].typed, plan[i].want);
         pause_sender();
      end

      // Finish the read under reset defaults with the largest positive reading
      run_read(16'h07FF, 15);

      foreach (settings[s]) begin
         wait_quiet(6);
         write_register(REG_TICKS_PER_US, {12'($urandom_range(0, 4095)), settings[s].tpu});
         write_register(REG_CONVERT_WAIT_US, settings[s].wait_us);
         csr_ch.valid <= 1'b0;
         if (settings[s].with_read) begin
            word = (settings[s].word == '0) ? 16'($urandom) : settings[s].word;
            run_read(word, settings[s].odds);
         end else begin
            repeat (40) begin
               offer(1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
               pause_sender();
            end
         end
      end

      wait_quiet(10);
      $display("Ran %0d transactions through %0d register settings in %0d cycles",
               items_sent, $size(settings) + 1, cycle_count);
      $display("Checked %0d results, %0d complete temperature reads", results_seen,
               reads_done);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/otr_pkg.sv
src/otr_if.sv
src/otr_core.sv
src/one_wire_temperature_reader.sv
test/testbench.sv
